// ----- rtl/mipa_pkg.sv -----
// ----------------------------------------------------------------------------
// mipa_pkg
// Shared constants, register indexes and a divide helper for the meter increment
// period archiver.
// ----------------------------------------------------------------------------
package mipa_pkg;

	// Field widths
	localparam int CountW   = 32;
	localparam int TimeW    = 32;
	localparam int PeriodW  = 16;
	localparam int OffsetW  = 8;
	localparam int MeterW   = 8;
	localparam int SecW     = 6;
	localparam int MinW     = 6;
	localparam int HourW    = 5;
	localparam int ElapsedW = 16;
	localparam int CfgIdxW  = 2;

	// Quotient width of a 32-bit time difference divided by 60
	localparam int QuotW = 27;

	// Counter wrap window and rule constants
	localparam logic [CountW-1:0]   WRAP_NEW_MAX  = 32'h0000_00ff;
	localparam logic [CountW-1:0]   WRAP_OLD_MIN  = 32'hffff_ff00;
	localparam logic [ElapsedW-1:0] ELAPSED_CAP   = 16'hffff;
	localparam logic [PeriodW-1:0]  MODE_TWO_HOUR = 16'd120;
	localparam logic [PeriodW-1:0]  MODE_DAY      = 16'd1440;
	localparam logic [PeriodW-1:0]  PERIOD_MIN    = 16'd3;
	localparam logic [QuotW-1:0]    ALIGN_MIN_EL  = 27'd5;
	localparam logic [MinW-1:0]     ALIGN_MINUTE  = 6'd5;
	localparam logic [OffsetW-1:0]  HOUR_LAST     = 8'd23;

	// ceil(2^35 / 15): exact quotient for any dividend below 2^32
	localparam logic [31:0] DIV15_RECIP = 32'h8888_8889;
	localparam int          DIV15_SHIFT = 35;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_PERIOD_MINUTES = 2'd0,
		CFG_HOUR_OFFSET    = 2'd1,
		CFG_METER_NUMBER   = 2'd2
	} cfg_idx_t;

	// Divide a time difference in seconds by 60: drop two bits, then
	// multiply by the reciprocal of 15 (a sum of constant shifts).
	function automatic logic [QuotW-1:0] div60(input logic [TimeW-1:0] diff);
		logic [29:0] x;
		logic [61:0] prod;
		x    = diff[TimeW-1:2];
		prod = 62'(x) * 62'(DIV15_RECIP);
		return prod[61:DIV15_SHIFT];
	endfunction

endpackage

// ----- rtl/meter_increment_period_archiver_core.sv -----
// ----------------------------------------------------------------------------
// meter_increment_period_archiver_core
// Accumulates meter count increments per period and emits archive records.
// ----------------------------------------------------------------------------
// One result per item, one item per clock unless out_stall holds back a
// result. An accepted item sits in the input register until a single
// combinational pass (wrap-aware count delta, elapsed-minute divide by 60 as
// a constant multiply, period rule) updates the state registers and loads the
// result register, which shows the result until it is taken. The result
// register frees the input side, so in_stall rises only while a result is
// held by out_stall and the next one is already waiting. Configuration writes
// are always taken (cfg_ready is tied high) and must only happen while the
// block is idle.
// ----------------------------------------------------------------------------
module meter_increment_period_archiver_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mipa_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [31:0]                         cfg_data,
	// scan item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mipa_pkg::CountW-1:0]         count_value,
	input  logic [mipa_pkg::TimeW-1:0]          now_seconds,
	input  logic [mipa_pkg::SecW-1:0]           clock_second,
	input  logic [mipa_pkg::MinW-1:0]           clock_minute,
	input  logic [mipa_pkg::HourW-1:0]          clock_hour,
	input  logic                                first_run,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mipa_pkg::CountW-1:0]         accumulated,
	output logic                                period_done,
	output logic                                record_valid,
	output logic [mipa_pkg::MeterW-1:0]         record_meter,
	output logic [mipa_pkg::CountW-1:0]         record_total,
	output logic [mipa_pkg::TimeW-1:0]          record_start,
	output logic [mipa_pkg::ElapsedW-1:0]       record_elapsed
);

	// Configuration registers
	logic [mipa_pkg::PeriodW-1:0]  period_minutes_q;
	logic [mipa_pkg::OffsetW-1:0]  hour_offset_q;
	logic [mipa_pkg::MeterW-1:0]   meter_number_q;

	// Period state
	logic [mipa_pkg::CountW-1:0]   last_count_q;
	logic [mipa_pkg::CountW-1:0]   increment_sum_q;
	logic [mipa_pkg::TimeW-1:0]    period_start_q;
	logic                          done_flag_q;

	// Input register
	logic                          valid_s1;
	logic [mipa_pkg::CountW-1:0]   count_value_s1;
	logic [mipa_pkg::TimeW-1:0]    now_seconds_s1;
	logic [mipa_pkg::SecW-1:0]     clock_second_s1;
	logic [mipa_pkg::MinW-1:0]     clock_minute_s1;
	logic [mipa_pkg::HourW-1:0]    clock_hour_s1;
	logic                          first_run_s1;

	// Result register
	logic                          out_valid_q;
	logic [mipa_pkg::CountW-1:0]   accumulated_q;
	logic                          period_done_q;
	logic                          record_valid_q;
	logic [mipa_pkg::MeterW-1:0]   record_meter_q;
	logic [mipa_pkg::CountW-1:0]   record_total_q;
	logic [mipa_pkg::TimeW-1:0]    record_start_q;
	logic [mipa_pkg::ElapsedW-1:0] record_elapsed_q;

	// Single-pass results
	logic                          advance;
	logic                          take_in;
	logic [mipa_pkg::CountW-1:0]   last_base;
	logic [mipa_pkg::TimeW-1:0]    start_base;
	logic [mipa_pkg::HourW-1:0]    hour_off_eff;
	logic                          disabled;
	logic                          count_wrap;
	logic                          count_add;
	logic [mipa_pkg::CountW-1:0]   sum_base;
	logic [mipa_pkg::CountW-1:0]   sum_new;
	logic [mipa_pkg::QuotW-1:0]    elapsed;
	logic [mipa_pkg::QuotW-1:0]    period_ext;
	logic                          rule_period;
	logic                          rule_cap;
	logic                          rule_two_hour;
	logic                          rule_day;
	logic                          fire;

	// Handshake: the input register moves on whenever the result register is
	// free or being emptied this cycle
	assign advance   = valid_s1 & ~(out_valid_q & out_stall);
	assign in_stall  = valid_s1 & out_valid_q & out_stall;
	assign take_in   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// Hold configuration registers, write on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_minutes_q <= '0;
			hour_offset_q    <= '0;
			meter_number_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mipa_pkg::CFG_PERIOD_MINUTES: period_minutes_q <= cfg_data[mipa_pkg::PeriodW-1:0];
				mipa_pkg::CFG_HOUR_OFFSET:    hour_offset_q    <= cfg_data[mipa_pkg::OffsetW-1:0];
				mipa_pkg::CFG_METER_NUMBER:   meter_number_q   <= cfg_data[mipa_pkg::MeterW-1:0];
				default: ;
			endcase
		end
	end

	// Capture the item into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			count_value_s1  <= count_value;
			now_seconds_s1  <= now_seconds;
			clock_second_s1 <= clock_second;
			clock_minute_s1 <= clock_minute;
			clock_hour_s1   <= clock_hour;
			first_run_s1    <= first_run;
		end
	end

	// Work out the period step for the item in the input register
	always_comb begin
		// first run reloads start time and last count before anything else
		last_base  = first_run_s1 ? count_value_s1 : last_count_q;
		start_base = first_run_s1 ? now_seconds_s1 : period_start_q;
		disabled   = (period_minutes_q < mipa_pkg::PERIOD_MIN);

		// offsets past the last hour of the day act as zero
		hour_off_eff = (hour_offset_q > mipa_pkg::HOUR_LAST) ? '0
		                                                     : hour_offset_q[mipa_pkg::HourW-1:0];

		// add rising counts, and counts that wrapped through the top
		count_wrap = (count_value_s1 <= mipa_pkg::WRAP_NEW_MAX) &&
		             (last_base > mipa_pkg::WRAP_OLD_MIN);
		count_add  = (count_value_s1 > last_base) || count_wrap;
		sum_base   = done_flag_q ? '0 : increment_sum_q;
		sum_new    = count_add ? (sum_base + (count_value_s1 - last_base)) : sum_base;

		// elapsed minutes; a start time in the future reads as the cap
		if (now_seconds_s1 >= start_base) begin
			elapsed = mipa_pkg::div60(now_seconds_s1 - start_base);
		end else begin
			elapsed = mipa_pkg::QuotW'(mipa_pkg::ELAPSED_CAP);
		end
		period_ext = mipa_pkg::QuotW'(period_minutes_q);

		rule_period   = (elapsed >= period_ext) &&
		                (period_minutes_q != mipa_pkg::MODE_TWO_HOUR);
		rule_cap      = (elapsed >= mipa_pkg::QuotW'(mipa_pkg::ELAPSED_CAP));
		rule_two_hour = (elapsed >= mipa_pkg::ALIGN_MIN_EL) &&
		                (period_minutes_q == mipa_pkg::MODE_TWO_HOUR) &&
		                (clock_minute_s1 < mipa_pkg::ALIGN_MINUTE) &&
		                ((clock_hour_s1[0] ^ hour_off_eff[0]) == 1'b0);
		rule_day      = (elapsed >= mipa_pkg::ALIGN_MIN_EL) &&
		                (period_minutes_q == mipa_pkg::MODE_DAY) &&
		                (clock_minute_s1 == '0) &&
		                (clock_hour_s1 == hour_off_eff);
		fire = !disabled && (clock_second_s1 == '0) &&
		       (rule_period || rule_cap || rule_two_hour || rule_day);
	end

	// Advance the period state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q    <= '0;
			increment_sum_q <= '0;
			period_start_q  <= '0;
			done_flag_q     <= 1'b0;
		end else if (advance) begin
			last_count_q <= count_value_s1;
			done_flag_q  <= fire;
			if (disabled) begin
				increment_sum_q <= '0;
				period_start_q  <= now_seconds_s1;
			end else begin
				increment_sum_q <= sum_new;
				period_start_q  <= fire ? now_seconds_s1 : start_base;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			accumulated_q    <= disabled ? '0 : sum_new;
			period_done_q    <= fire;
			record_valid_q   <= fire;
			record_meter_q   <= fire ? meter_number_q : '0;
			record_total_q   <= fire ? sum_new : '0;
			record_start_q   <= fire ? start_base : '0;
			record_elapsed_q <= fire ? elapsed[mipa_pkg::ElapsedW-1:0] : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign accumulated    = accumulated_q;
	assign period_done    = period_done_q;
	assign record_valid   = record_valid_q;
	assign record_meter   = record_meter_q;
	assign record_total   = record_total_q;
	assign record_start   = record_start_q;
	assign record_elapsed = record_elapsed_q;

endmodule

// ----- rtl/mipa_checker.sv -----
// ----------------------------------------------------------------------------
// mipa_checker
// Port-level checks for the meter increment period archiver.
// ----------------------------------------------------------------------------
module mipa_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [mipa_pkg::CountW-1:0]         accumulated,
	input  logic                                period_done,
	input  logic                                record_valid,
	input  logic [mipa_pkg::MeterW-1:0]         record_meter,
	input  logic [mipa_pkg::CountW-1:0]         record_total,
	input  logic [mipa_pkg::TimeW-1:0]          record_start,
	input  logic [mipa_pkg::ElapsedW-1:0]       record_elapsed
);

	// A record goes out on exactly the item that closes the period
	a_done_matches_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_valid == period_done))
		else $error("period_done and record_valid disagree");

	// Without a record, all record fields read zero
	a_empty_record_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !record_valid) |->
		(record_meter == '0 && record_total == '0 && record_start == '0 &&
		 record_elapsed == '0))
		else $error("record fields not zero without a record");

	// The archived total is the sum shown on the same item
	a_record_total_is_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && record_valid) |-> (record_total == accumulated))
		else $error("record total differs from accumulated sum");

	// The input side stalls only while a result is held back
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |-> (out_valid && out_stall))
		else $error("input stalled with the result side free");

	// A held result does not change
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(accumulated) && $stable(record_valid) &&
		 $stable(record_total)))
		else $error("result changed while stalled");

endmodule

bind meter_increment_period_archiver_core mipa_checker u_mipa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.accumulated    (accumulated),
	.period_done    (period_done),
	.record_valid   (record_valid),
	.record_meter   (record_meter),
	.record_total   (record_total),
	.record_start   (record_start),
	.record_elapsed (record_elapsed)
);
